@@ hdl/assert_macros.svh @@
// Assertion macros shared by the primitive polynomial check unit.
// Each macro expands to one labeled concurrent assertion on a clock and active-low reset.
// No other files are needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The property must never hold at a clock edge outside reset.
`define PPC_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

@@ hdl/ppc_pkg.sv @@
// Types and constants for the primitive polynomial check unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package ppc_pkg;

	localparam int CfgWidth    = 4;
	localparam int MinDegree   = 2;
	localparam int DegreeReset = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} ppc_state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic rd;
		logic step;
		logic emit;
	} ppc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic stop;
		logic out_busy;
	} ppc_sts_t;

endpackage

@@ hdl/ppc_ctrl.sv @@
// Controller state machine of the primitive polynomial check unit.
// Sequences the map clear, the LFSR walk and the result hand-off; uses ppc_pkg.
`include "assert_macros.svh"

module ppc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ppc_pkg::ppc_sts_t sts,
	output ppc_pkg::ppc_cmd_t cmd
);

	ppc_pkg::ppc_state_t state_q;
	ppc_pkg::ppc_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ppc_pkg::ST_IDLE: begin
				if (in_valid) state_next = ppc_pkg::ST_CLEAR;
			end
			ppc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_next = ppc_pkg::ST_READ;
			end
			ppc_pkg::ST_READ: begin
				state_next = ppc_pkg::ST_CHECK;
			end
			ppc_pkg::ST_CHECK: begin
				state_next = sts.stop ? ppc_pkg::ST_DONE : ppc_pkg::ST_READ;
			end
			ppc_pkg::ST_DONE: begin
				if (!sts.out_busy) state_next = ppc_pkg::ST_IDLE;
			end
			default: begin
				state_next = ppc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ppc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ppc_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ppc_pkg::ST_READ: begin
				cmd.rd = 1'b1;
			end
			ppc_pkg::ST_CHECK: begin
				cmd.step = !sts.stop;
			end
			ppc_pkg::ST_DONE: begin
				cmd.emit = !sts.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	`PPC_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "more than one datapath command")
	`PPC_NEVER(a_emit_busy, clk, arst_n, cmd.emit && sts.out_busy, "result emitted over a held one")
	`PPC_ASSERT(a_load_clear, clk, arst_n, cmd.load |=> state_q == ppc_pkg::ST_CLEAR,
		"load not followed by map clear")

endmodule

@@ hdl/ppc_dpath.sv @@
// Datapath of the primitive polynomial check unit: degree register, LFSR, step counter,
// visited-state memory and result register. Uses ppc_pkg.
`include "assert_macros.svh"

module ppc_dpath #(
	parameter int MAX_DEGREE = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppc_pkg::ppc_cmd_t            cmd,
	output ppc_pkg::ppc_sts_t            sts,
	input  logic [MAX_DEGREE-1:0]        candidate,
	input  logic                         cfg_we,
	input  logic [ppc_pkg::CfgWidth-1:0] cfg_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [MAX_DEGREE:0]          poly_out,
	output logic                         prim_out,
	output logic [MAX_DEGREE-1:0]        cnt_out
);

	localparam int MW    = MAX_DEGREE;
	localparam int EW    = $clog2(MAX_DEGREE + 1);
	localparam int Depth = 1 << MAX_DEGREE;

	logic [ppc_pkg::CfgWidth-1:0] deg_q;
	logic [EW-1:0]                eff_deg;
	logic [MW:0]                  top_c;
	logic [MW-1:0]                mask_c;

	logic [MW:0]   poly_q;
	logic [MW:0]   top_q;
	logic [MW-1:0] mask_q;
	logic [MW-1:0] clr_q;
	logic [MW-1:0] s_q;
	logic [MW-1:0] cnt_q;
	logic          rd_data_q;
	logic          out_valid_q;

	logic [MW:0]   shifted;
	logic [MW:0]   fed_back;
	logic          we;
	logic [MW-1:0] waddr;
	logic          wdata;

	logic mem [0:Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= ppc_pkg::CfgWidth'(ppc_pkg::DegreeReset);
		end else if (cfg_we) begin
			deg_q <= cfg_data;
		end
	end

	// Degrees outside the supported range are clamped to its ends.
	always_comb begin
		if (int'(deg_q) > MW) begin
			eff_deg = EW'(MW);
		end else if (int'(deg_q) < ppc_pkg::MinDegree) begin
			eff_deg = EW'(ppc_pkg::MinDegree);
		end else begin
			eff_deg = EW'(deg_q);
		end
	end

	always_comb begin
		for (int i = 0; i <= MW; i++) begin
			top_c[i] = (EW'(i) == eff_deg);
		end
		for (int i = 0; i < MW; i++) begin
			mask_c[i] = (EW'(i) < eff_deg);
		end
	end

	assign shifted  = {s_q, 1'b0};
	assign fed_back = (|(shifted & top_q)) ? (shifted ^ poly_q) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cnt_q  <= '0;
			clr_q  <= '0;
			s_q    <= MW'(1);
		end else begin
			if (cmd.load) begin
				mask_q <= mask_c;
				cnt_q  <= '0;
				clr_q  <= '0;
				s_q    <= MW'(1);
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
				s_q   <= fed_back[MW-1:0] & mask_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			poly_q <= top_c | {1'b0, candidate & mask_c};
			top_q  <= top_c;
		end
	end

	// One write port serves both the clear sweep and the visit marks.
	assign we    = cmd.clr || cmd.step;
	assign waddr = cmd.clr ? clr_q : s_q;
	assign wdata = cmd.step;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[s_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			poly_out <= poly_q;
			prim_out <= (cnt_q == mask_q);
			cnt_out  <= cnt_q;
		end
	end

	// The walk ends at the step limit, at the zero state or at a state already marked.
	assign sts.clr_last = (clr_q == mask_q);
	assign sts.stop     = (cnt_q == mask_q) || (s_q == '0) || rd_data_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;

	`PPC_NEVER(a_mark_zero, clk, arst_n, cmd.step && (s_q == '0), "zero state marked as visited")
	`PPC_NEVER(a_step_seen, clk, arst_n, cmd.step && rd_data_q, "walk stepped from a visited state")
	`PPC_NEVER(a_cnt_range, clk, arst_n, cmd.emit && ((cnt_q & ~mask_q) != '0),
		"cycle length beyond the degree range")

endmodule

@@ hdl/primitive_polynomial_check_unit.sv @@
// Primitive polynomial check unit over GF(2), top level.
// Instantiates ppc_ctrl and ppc_dpath; uses ppc_pkg.
//
// Usage: the degree register is written over cfg_valid/cfg_ready/cfg_data (always ready)
// while the unit is idle; it resets to 4. A candidate item enters on s_tvalid/s_tready,
// its lower coefficient bits in s_tdata; s_tready is high only while no item is in work.
// Each item gives one result item on m_tvalid/m_tready: the full polynomial and the
// count of distinct states in m_tdata, the primitive flag in m_tuser.
// Work per item at degree d: a load, a clear of the 2^d entries of the visited-state memory
// (one entry per cycle through its single write port), then the LFSR walk, each step a
// memory read followed by a check and mark, and finally the hand-off of the result.
// Items are worked on one at a time.
// The result register holds a finished item while the receiver stalls; the next candidate
// is still taken and walked, and waits before hand-off until the register is free.
// Reset clears the control state and restores the degree; the memory needs no reset,
// as every item clears the entries it may read.

module primitive_polynomial_check_unit #(
	parameter int MAX_DEGREE = 12
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// candidate in [MAX_DEGREE-1:0], zero padding above
	input  logic [((MAX_DEGREE+7)/8)*8-1:0]          s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// polynomial in [MAX_DEGREE:0], cycle_length above it, zero padding at the top
	output logic [((2*MAX_DEGREE+8)/8)*8-1:0]        m_tdata,
	// is_primitive
	output logic                                     m_tuser,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [ppc_pkg::CfgWidth-1:0]             cfg_data
);

	localparam int OutW = ((2 * MAX_DEGREE + 8) / 8) * 8;

	ppc_pkg::ppc_cmd_t cmd;
	ppc_pkg::ppc_sts_t sts;

	logic [MAX_DEGREE:0]   poly_out;
	logic [MAX_DEGREE-1:0] cnt_out;

	assign cfg_ready = 1'b1;

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppc_dpath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.candidate (s_tdata[MAX_DEGREE-1:0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.poly_out  (poly_out),
		.prim_out  (m_tuser),
		.cnt_out   (cnt_out)
	);

	assign m_tdata = OutW'({cnt_out, poly_out});

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for primitive_polynomial_check_unit.
// Depends on ppc_pkg and the unit's RTL. It predicts each verdict by walking the LFSR
// itself, then compares every result item while both stream sides idle and stall at random.
module tb;

	localparam int MAX_DEG = 12;
	localparam int CAND_W = MAX_DEG;
	localparam int POLY_W = MAX_DEG + 1;
	localparam int IN_W = ((MAX_DEG + 7) / 8) * 8;
	localparam int OUT_W = ((2 * MAX_DEG + 8) / 8) * 8;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef logic [ppc_pkg::CfgWidth-1:0] degree_code_t;

	typedef struct packed {
		logic [POLY_W-1:0]  polynomial;
		logic               is_primitive;
		logic [CAND_W-1:0]  cycle_length;
	} poly_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	degree_code_t cfg_data = '0;

	poly_verdict_t pending_verdicts[$];
	degree_code_t degree_reg = degree_code_t'(ppc_pkg::DegreeReset);
	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int primitive_seen = 0;
	int degree_writes = 0;
	int cycle_count = 0;
	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;
	int hold_len = 0;
	int hold_req_count = 0;
	int hold_seen = 0;
	int rx_stall_left = 0;

	primitive_polynomial_check_unit #(
		.MAX_DEGREE(MAX_DEG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		// candidate, zero padding above
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		// polynomial, cycle_length, zero padding at the top
		.m_tdata(m_tdata),
		// is_primitive
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Walks the LFSR from state 1 until it revisits a state, reaches zero or has taken
	// 2^degree-1 steps; out-of-range degree codes are clamped first.
	function automatic poly_verdict_t walk_polynomial(input degree_code_t code,
			input logic [CAND_W-1:0] cand);
		bit seen [0:(1 << MAX_DEG)-1];
		int d;
		int top;
		int step_limit;
		int poly;
		int s;
		int count;
		poly_verdict_t v;
		d = int'(code);
		if (d < ppc_pkg::MinDegree) begin
			d = ppc_pkg::MinDegree;
		end
		if (d > MAX_DEG) begin
			d = MAX_DEG;
		end
		top = 1 << d;
		step_limit = top - 1;
		poly = top | (int'(cand) & step_limit);
		s = 1;
		count = 0;
		foreach (seen[i]) begin
			seen[i] = 1'b0;
		end
		for (int n = 0; n < step_limit; n++) begin
			if (s == 0 || seen[s]) begin
				break;
			end
			seen[s] = 1'b1;
			count++;
			s = s << 1;
			if ((s & top) != 0) begin
				s = s ^ poly;
			end
			s = s & step_limit;
		end
		v.polynomial = poly[POLY_W-1:0];
		v.is_primitive = (count == step_limit);
		v.cycle_length = count[CAND_W-1:0];
		return v;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 200);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever a test requests one.
	always @(posedge clk) begin
		if (hold_seen != hold_req_count) begin
			hold_seen = hold_req_count;
			rx_stall_left = hold_len;
		end
		if (rx_stall_left > 0) begin
			m_tready <= 1'b0;
			rx_stall_left--;
		end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			rx_stall_left = gap_cycles();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		poly_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result item: polynomial %h", m_tdata[POLY_W-1:0]);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				results_checked++;
				if (want.is_primitive) begin
					primitive_seen++;
				end
				if (m_tdata[POLY_W-1:0] !== want.polynomial) begin
					$error("polynomial mismatch: expected %h, got %h",
						want.polynomial, m_tdata[POLY_W-1:0]);
					error_count++;
				end
				if (m_tdata[POLY_W+CAND_W-1:POLY_W] !== want.cycle_length) begin
					$error("cycle_length mismatch: expected %0d, got %0d",
						want.cycle_length, m_tdata[POLY_W+CAND_W-1:POLY_W]);
					error_count++;
				end
				if (m_tuser !== want.is_primitive) begin
					$error("is_primitive mismatch: expected %b, got %b",
						want.is_primitive, m_tuser);
					error_count++;
				end
			end
		end
	end

	// Called at a rising edge. Valid stays high when the next item follows at once.
	task automatic send_candidate(input logic [CAND_W-1:0] cand);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(cand);
		do @(posedge clk); while (!s_tready);
		pending_verdicts.push_back(walk_polynomial(degree_reg, cand));
		items_sent++;
		gap = tx_gaps_on ? gap_cycles() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// Every item yields a result, so an empty queue means the unit is idle.
	task automatic write_degree(input degree_code_t code);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		degree_reg = code;
		degree_writes++;
	endtask

	task automatic test_reset_degree();
		send_candidate(12'h000);
		send_candidate(12'h003);
		send_candidate(12'hFFF);
		send_candidate(12'hFF9);
		wait_drained();
	endtask

	// Degree extremes, clamped codes, masked upper candidate bits and the all-zero
	// candidate whose walk falls into state zero.
	task automatic test_degree_edges();
		write_degree(degree_code_t'(2));
		send_candidate(12'h000);
		send_candidate(12'h001);
		send_candidate(12'h003);
		send_candidate(12'hFFF);
		write_degree(degree_code_t'(0));
		send_candidate(12'h003);
		write_degree(degree_code_t'(1));
		send_candidate(12'hAAA);
		write_degree(degree_code_t'(8));
		send_candidate(12'h01D);
		send_candidate(12'h900);
		write_degree(degree_code_t'(12));
		send_candidate(12'h053);
		send_candidate(12'hFFF);
		send_candidate(12'h000);
		write_degree(degree_code_t'(15));
		send_candidate(12'h053);
		write_degree(degree_code_t'(13));
		send_candidate(12'h800);
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering, so the result register
	// and the walk both fill and the input stalls.
	task automatic test_fill_and_stall();
		write_degree(degree_code_t'(3));
		tx_gaps_on = 1'b0;
		hold_len <= 2500;
		hold_req_count <= hold_req_count + 1;
		for (int i = 0; i < 6; i++) begin
			send_candidate(12'($urandom));
		end
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_candidates();
		int r;
		logic [CAND_W-1:0] cand;
		for (int phase = 0; phase < 8; phase++) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				write_degree(degree_code_t'($urandom_range(0, 1)));
			end else if (r == 1) begin
				write_degree(degree_code_t'($urandom_range(9, 11)));
			end else begin
				write_degree(degree_code_t'($urandom_range(2, 8)));
			end
			// The first phase runs with no idling on either side.
			tx_gaps_on = (phase != 0);
			rx_stalls_on <= (phase != 0);
			for (int i = 0; i < 10; i++) begin
				cand = 12'($urandom);
				if ($urandom_range(0, 1) == 1) begin
					cand[0] = 1'b1;
				end
				send_candidate(cand);
				if (phase == 3 && i == 5) begin
					wait_drained();
				end
			end
			wait_drained();
		end
		tx_gaps_on = 1'b1;
		rx_stalls_on <= 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_degree();
		test_degree_edges();
		test_fill_and_stall();
		test_random_candidates();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Checked %0d results (%0d primitive) from %0d candidates.",
			results_checked, primitive_seen, items_sent);
		$display("Degree register written %0d times, clamped codes and a long hold-off included.",
			degree_writes);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
